// ===== hw/rtl/pli_pkg.sv =====
// Shared types and constants for the positional list block.
// Used by pli_cell and positional_list_insert_delete; depends on nothing.
package pli_pkg;

    localparam int ValueWidth = 32;
    localparam int PosWidth   = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SHOW   = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_POS   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHOW
    } state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_ROTATE
    } cell_mode_t;

    // Broadcast to every cell: first is the zero-based target slot,
    // tail is the zero-based slot of the last held entry.
    typedef struct packed {
        cell_mode_t          mode;
        logic [PosWidth-1:0] first;
        logic [PosWidth-1:0] tail;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/positional_list_insert_delete.sv =====
// Top level of the positional list: command control and the chain of cells.
// Depends on pli_pkg and pli_cell.
//
// A command transfers at a rising edge where start is high and busy is low.
// Insert, delete and every rejected command finish without busy: the cells shift
// in parallel at the transfer edge and one result appears with result_valid
// in the next cycle, while busy stays low, so a new command may follow at
// once. Show on a non-empty list holds busy high in the show state and
// delivers one entry per cycle, as the held entries rotate through the head
// cell of the chain; last marks the final one. The receiver cannot stall:
// each result is present for exactly one cycle.
module positional_list_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             op,
    input  logic signed [pli_pkg::ValueWidth-1:0]  value,
    input  logic [pli_pkg::PosWidth-1:0]           position,
    output logic                                   result_valid,
    output pli_pkg::status_t                       status,
    output logic signed [pli_pkg::ValueWidth-1:0]  element,
    output logic [5:0]                             element_count,
    output logic                                   last
);
    import pli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] show_idx_reg;
    logic [CW-1:0] show_idx_next;

    logic                     res_valid_reg;
    logic                     res_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [ValueWidth-1:0] element_reg;
    logic signed [ValueWidth-1:0] element_next;
    logic                     last_reg;
    logic                     last_next;

    cell_ctrl_t ctrl;
    logic signed [ValueWidth-1:0] cell_data [CAPACITY];

    logic          accept;
    logic [8:0]    pos_ext;
    logic [8:0]    cnt_ext;
    logic          ins_pos_ok;
    logic          del_pos_ok;
    logic          full;
    logic [CW-1:0] cnt_minus_one;
    logic          show_last;
    logic [CW+5:0] cnt_wide;

    assign accept        = start && (state_reg == S_IDLE);
    assign pos_ext       = {1'b0, position};
    assign cnt_ext       = 9'(cnt_reg);
    assign ins_pos_ok    = (position != '0) && (pos_ext <= cnt_ext + 9'd1);
    assign del_pos_ok    = (position != '0) && (pos_ext <= cnt_ext);
    assign full          = (cnt_reg == CW'(CAPACITY));
    assign cnt_minus_one = cnt_reg - CW'(1);
    assign show_last     = (show_idx_reg == cnt_minus_one);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_SHOW) && (cnt_reg != '0))
                begin
                    state_next = S_SHOW;
                end
            end
            S_SHOW:
            begin
                if (show_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs, cell control and count update.
    always_comb
    begin
        ctrl.mode      = CM_HOLD;
        ctrl.first     = position - PosWidth'(1);
        ctrl.tail      = PosWidth'(cnt_minus_one);
        cnt_next       = cnt_reg;
        show_idx_next  = show_idx_reg;
        res_valid_next = 1'b0;
        status_next    = STAT_OK;
        element_next   = '0;
        last_next      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                show_idx_next = '0;
                if (accept)
                begin
                    case (op)
                        OP_INSERT:
                        begin
                            res_valid_next = 1'b1;
                            if (!ins_pos_ok)
                            begin
                                status_next = STAT_POS;
                            end
                            else if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.mode = CM_INSERT;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            res_valid_next = 1'b1;
                            if (!del_pos_ok)
                            begin
                                status_next = STAT_POS;
                            end
                            else
                            begin
                                ctrl.mode = CM_DELETE;
                                cnt_next  = cnt_minus_one;
                            end
                        end
                        OP_SHOW:
                        begin
                            // A non-empty show produces its items from the
                            // show state instead.
                            if (cnt_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                                status_next    = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            status_next    = STAT_POS;
                        end
                    endcase
                end
            end
            S_SHOW:
            begin
                ctrl.mode      = CM_ROTATE;
                res_valid_next = 1'b1;
                element_next   = cell_data[0];
                last_next      = show_last;
                show_idx_next  = show_idx_reg + CW'(1);
            end
            default:
            begin
                ctrl.mode = CM_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            show_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            show_idx_reg  <= show_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [ValueWidth-1:0] left_d;
            logic signed [ValueWidth-1:0] right_d;
            if (gi == 0)
            begin : g_head
                assign left_d = value;
            end
            else
            begin : g_mid
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_d = cell_data[gi];
            end
            else
            begin : g_inner
                assign right_d = cell_data[gi+1];
            end
            pli_cell #(
                .IDX(gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .value     (value),
                .left_data (left_d),
                .right_data(right_d),
                .head_data (cell_data[0]),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    assign cnt_wide      = {6'd0, cnt_reg};
    assign busy          = (state_reg == S_SHOW);
    assign result_valid  = res_valid_reg;
    assign status        = status_reg;
    assign element       = element_reg;
    assign element_count = cnt_wide[5:0];
    assign last          = last_reg;

    // A show item that is not the final one is always followed by another.
    a_show_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("show stream broke before its final item");

    // Every command other than show answers with a single final item.
    a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_SHOW)) |=> (result_valid && last))
        else $error("single-item command gave no final result");

    // Each busy cycle delivers one entry in the next cycle.
    a_busy_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid)
        else $error("show cycle produced no result");

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

endmodule

// ===== hw/rtl/pli_cell.sv =====
// One slot of the list chain: holds one entry and loads from its neighbors, the new value or the head slot.
// Depends on pli_pkg for the control struct and widths.
module pli_cell #(
    parameter int IDX = 0
) (
    input  logic                                   clk,
    input  pli_pkg::cell_ctrl_t                    ctrl,
    input  logic signed [pli_pkg::ValueWidth-1:0]  value,
    input  logic signed [pli_pkg::ValueWidth-1:0]  left_data,
    input  logic signed [pli_pkg::ValueWidth-1:0]  right_data,
    input  logic signed [pli_pkg::ValueWidth-1:0]  head_data,
    output logic signed [pli_pkg::ValueWidth-1:0]  data
);
    import pli_pkg::*;

    localparam logic [PosWidth-1:0] MyIdx = PosWidth'(IDX);

    logic signed [ValueWidth-1:0] data_reg;
    logic signed [ValueWidth-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            CM_INSERT:
            begin
                if (MyIdx == ctrl.first)
                begin
                    data_next = value;
                end
                else if (MyIdx > ctrl.first)
                begin
                    data_next = left_data;
                end
            end
            CM_DELETE:
            begin
                if (MyIdx >= ctrl.first)
                begin
                    data_next = right_data;
                end
            end
            CM_ROTATE:
            begin
                // The held entries turn as a ring so that the head slot
                // presents each one in order and the list is whole again
                // once every entry has been presented.
                if (MyIdx < ctrl.tail)
                begin
                    data_next = right_data;
                end
                else if (MyIdx == ctrl.tail)
                begin
                    data_next = head_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
